[rtl/core/mhtq_pkg.sv]
// Shared types, constants and helper functions of the min-heap timer queue.
package mhtq_pkg;

  localparam int CAPACITY = 64;
  localparam int ID_BITS  = 8;
  localparam int TIME_W   = 32;

  // Heap nodes are numbered from 1; node k sits at level floor(log2(k)).
  localparam int NODE_W    = $clog2(CAPACITY + 1);
  localparam int PAIR_W    = NODE_W - 1;
  localparam int SHIFT_W   = $clog2(NODE_W);
  localparam int NUM_CELLS = NODE_W - 1;

  localparam logic [1:0] MODE_ADD      = 2'd0;
  localparam logic [1:0] MODE_QUERY    = 2'd1;
  localparam logic [1:0] MODE_COMPLETE = 2'd2;

  localparam logic [1:0] OP_INS   = 2'd0;
  localparam logic [1:0] OP_SDN   = 2'd1;
  localparam logic [1:0] OP_FETCH = 2'd2;

  typedef logic [ID_BITS-1:0] id_t;

  typedef struct packed {
    logic [TIME_W-1:0] run_time;
    id_t               id;
  } elem_t;

  // Siblings 2m and 2m+1 share one memory word.
  typedef struct packed {
    elem_t odd;
    elem_t even;
  } pair_t;

  typedef struct packed {
    logic              valid;
    logic [1:0]        op;
    logic              disp;
    logic [NODE_W-1:0] k;
    logic [NODE_W-1:0] t;
    logic [SHIFT_W-1:0] s;
    logic [NODE_W-1:0] n;
    elem_t             e;
  } tok_t;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic [NODE_W-1:0] k;
    elem_t             e;
  } wb_t;

  typedef struct packed {
    logic  done;
    logic  fetch_valid;
    elem_t fetch_elem;
  } stat_t;

  function automatic int addr_bits(int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  // Number of sibling pairs stored at a level (level 1 and deeper).
  function automatic int level_depth(int lvl);
    int first;
    int span;
    first = 1 << (lvl - 1);
    span  = (CAPACITY >> 1) - first + 1;
    return (span < first) ? span : first;
  endfunction

  function automatic logic [SHIFT_W-1:0] floor_log2(logic [NODE_W-1:0] v);
    logic [SHIFT_W-1:0] r;
    r = '0;
    for (int i = 0; i < NODE_W; i++) begin
      if (v[i]) r = SHIFT_W'(i);
    end
    return r;
  endfunction

endpackage

[rtl/core/mhtq_req_if.sv]
// Request channel of the min-heap timer queue.
interface mhtq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  task_id;
  logic [31:0] time_value;
  logic [31:0] now_time;

  modport source (output valid, mode, task_id, time_value, now_time, input ready);
  modport sink   (input valid, mode, task_id, time_value, now_time, output ready);
endinterface

[rtl/core/mhtq_rsp_if.sv]
// Result channel of the min-heap timer queue.
interface mhtq_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  earliest_id;
  logic [31:0] wait_time;
  logic        queue_empty;
  logic        overflow;
  logic [6:0]  task_count;

  modport source (output valid, earliest_id, wait_time, queue_empty, overflow, task_count,
                  input ready);
  modport sink   (input valid, earliest_id, wait_time, queue_empty, overflow, task_count,
                  output ready);
endinterface

[rtl/core/min_heap_timer_queue.sv]
// Top level of the min-heap timer queue: root register, sequencer and the chain of level cells.
//
//   Channel  Role    Transfer moves
//   req      sink    mode, task_id, time_value, now_time
//   rsp      source  earliest_id, wait_time, queue_empty, overflow, task_count
//
// Steps: query, a dropped add and a complete on an empty queue go straight to the result;
// an add walks the path to the new leaf top-down and a reschedule sifts the root down;
// a retire first walks down to fetch the last task and then sifts it down from the root.
// Each level cell registers its memory read and then registers its decision.
// Reset (synchronous, rst high) empties the queue; the level memories are not cleared.
// A new request is taken while the previous result still waits on rsp; the block holds in
// its final state only when a result is done and the one before it has not been taken.
module min_heap_timer_queue (
  input  logic       clk,
  input  logic       rst,
  mhtq_req_if.sink   req,
  mhtq_rsp_if.source rsp
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state;

  // Heap root (node 1) lives in flip-flops; deeper levels live in the cell memories.
  mhtq_pkg::elem_t             root;
  logic [mhtq_pkg::NODE_W-1:0] count;
  logic [31:0]                 now_q;
  logic                        drop_q;
  mhtq_pkg::tok_t              tok0;

  mhtq_pkg::tok_t  tok_link [mhtq_pkg::NUM_CELLS+1];
  mhtq_pkg::wb_t   wb_up    [mhtq_pkg::NUM_CELLS];
  mhtq_pkg::wb_t   wb_down  [mhtq_pkg::NUM_CELLS];
  mhtq_pkg::stat_t stat_a   [mhtq_pkg::NUM_CELLS];
  mhtq_pkg::wb_t   term_wb;

  logic            any_done;
  logic            any_fetch;
  mhtq_pkg::elem_t fetch_elem;

  mhtq_pkg::elem_t             new_elem;
  logic [mhtq_pkg::NODE_W-1:0] count_inc;
  logic [mhtq_pkg::NODE_W-1:0] count_dec;
  logic [mhtq_pkg::SHIFT_W-1:0] depth_inc;
  logic [mhtq_pkg::SHIFT_W-1:0] depth_cur;

  logic        wait_due;
  logic [31:0] wait_calc;

  assign tok_link[0] = tok0;
  assign req.ready   = (state == ST_IDLE);

  // A sift-down that leaves the deepest cell has no children left: it settles in place.
  always_comb begin
    term_wb       = '0;
    term_wb.valid = tok_link[mhtq_pkg::NUM_CELLS].valid &&
                    (tok_link[mhtq_pkg::NUM_CELLS].op == mhtq_pkg::OP_SDN);
    term_wb.last  = 1'b1;
    term_wb.k     = tok_link[mhtq_pkg::NUM_CELLS].k;
    term_wb.e     = tok_link[mhtq_pkg::NUM_CELLS].e;
  end

  for (genvar c = 0; c < mhtq_pkg::NUM_CELLS; c++) begin : g_level
    localparam int LVL   = c + 1;
    localparam int DEPTH = mhtq_pkg::level_depth(LVL);
    localparam int AW    = mhtq_pkg::addr_bits(DEPTH);

    logic [mhtq_pkg::PAIR_W-1:0] cell_addr;
    logic [mhtq_pkg::PAIR_W-1:0] local_addr;
    logic                        ram_we;
    mhtq_pkg::pair_t             ram_wdata;
    mhtq_pkg::pair_t             ram_rdata;

    if (c == mhtq_pkg::NUM_CELLS - 1) begin : g_last
      assign wb_down[c] = term_wb;
    end else begin : g_mid
      assign wb_down[c] = wb_up[c+1];
    end

    // Pair indices of this level start at 2^(LVL-1).
    assign local_addr = cell_addr - mhtq_pkg::PAIR_W'(1 << (LVL - 1));

    mhtq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .tok_in    (tok_link[c]),
      .tok_out   (tok_link[c+1]),
      .wb_in     (wb_down[c]),
      .wb_out    (wb_up[c]),
      .stat      (stat_a[c]),
      .ram_addr  (cell_addr),
      .ram_we    (ram_we),
      .ram_wdata (ram_wdata),
      .ram_rdata (ram_rdata)
    );

    mhtq_ram #(
      .WIDTH ($bits(mhtq_pkg::pair_t)),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk   (clk),
      .addr  (local_addr[AW-1:0]),
      .we    (ram_we),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
    );
  end

  // At most one cell reports a fetch at a time, so the results are simply merged.
  always_comb begin
    any_done   = 1'b0;
    any_fetch  = 1'b0;
    fetch_elem = '0;
    for (int c = 0; c < mhtq_pkg::NUM_CELLS; c++) begin
      any_done  = any_done | stat_a[c].done;
      any_fetch = any_fetch | stat_a[c].fetch_valid;
      if (stat_a[c].fetch_valid) begin
        fetch_elem = fetch_elem | stat_a[c].fetch_elem;
      end
    end
  end

  always_comb begin
    new_elem.run_time = req.time_value;
    new_elem.id       = mhtq_pkg::id_t'(req.task_id);
    count_inc         = count + mhtq_pkg::NODE_W'(1);
    count_dec         = count - mhtq_pkg::NODE_W'(1);
    depth_inc         = mhtq_pkg::floor_log2(count_inc);
    depth_cur         = mhtq_pkg::floor_log2(count);
    wait_due          = (count == '0) || (now_q >= root.run_time);
    wait_calc         = wait_due ? 32'd0 : (root.run_time - now_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      tok0      <= '0;
      drop_q    <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      tok0 <= '0;
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            now_q  <= req.now_time;
            drop_q <= 1'b0;
            state  <= ST_DONE;
            priority case (req.mode)
              mhtq_pkg::MODE_ADD: begin
                if (count >= mhtq_pkg::NODE_W'(mhtq_pkg::CAPACITY)) begin
                  drop_q <= 1'b1;
                end else begin
                  count <= count_inc;
                  if (count == '0) begin
                    root <= new_elem;
                  end else begin
                    // Root step of a top-down insert along the path to the new leaf.
                    tok0.valid <= 1'b1;
                    tok0.op    <= mhtq_pkg::OP_INS;
                    tok0.t     <= count_inc;
                    tok0.s     <= depth_inc - mhtq_pkg::SHIFT_W'(1);
                    tok0.n     <= count_inc;
                    tok0.k     <= '0;
                    if (new_elem.run_time < root.run_time) begin
                      root      <= new_elem;
                      tok0.e    <= root;
                      tok0.disp <= 1'b1;
                    end else begin
                      tok0.e    <= new_elem;
                      tok0.disp <= 1'b0;
                    end
                    state <= ST_RUN;
                  end
                end
              end
              mhtq_pkg::MODE_COMPLETE: begin
                if (count != '0) begin
                  if (req.time_value == 32'd0) begin
                    count <= count_dec;
                    if (count_dec != '0) begin
                      // The last task has to come up from its level before it can sift.
                      tok0.valid <= 1'b1;
                      tok0.op    <= mhtq_pkg::OP_FETCH;
                      tok0.t     <= count;
                      tok0.s     <= depth_cur - mhtq_pkg::SHIFT_W'(1);
                      tok0.n     <= count;
                      tok0.k     <= '0;
                      tok0.disp  <= 1'b0;
                      tok0.e     <= root;
                      state      <= ST_FETCH;
                    end
                  end else begin
                    root.run_time <= req.time_value;
                    if (count > mhtq_pkg::NODE_W'(1)) begin
                      tok0.valid      <= 1'b1;
                      tok0.op         <= mhtq_pkg::OP_SDN;
                      tok0.k          <= mhtq_pkg::NODE_W'(1);
                      tok0.t          <= '0;
                      tok0.s          <= '0;
                      tok0.n          <= count;
                      tok0.disp       <= 1'b0;
                      tok0.e.run_time <= req.time_value;
                      tok0.e.id       <= root.id;
                      state           <= ST_RUN;
                    end
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_FETCH: begin
          if (any_fetch) begin
            root <= fetch_elem;
            if (count > mhtq_pkg::NODE_W'(1)) begin
              tok0.valid <= 1'b1;
              tok0.op    <= mhtq_pkg::OP_SDN;
              tok0.k     <= mhtq_pkg::NODE_W'(1);
              tok0.t     <= '0;
              tok0.s     <= '0;
              tok0.n     <= count;
              tok0.disp  <= 1'b0;
              tok0.e     <= fetch_elem;
              state      <= ST_RUN;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_RUN: begin
          // The first cell's write-back targets the root register.
          if (wb_up[0].valid) begin
            root <= wb_up[0].e;
          end
          if (any_done || (wb_up[0].valid && wb_up[0].last)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result payload is loaded together with rsp.valid.
  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && (!rsp.valid || rsp.ready)) begin
      rsp.earliest_id <= (count == '0) ? 8'd0 : 8'(root.id);
      rsp.wait_time   <= wait_calc;
      rsp.queue_empty <= (count == '0);
      rsp.overflow    <= drop_q;
      rsp.task_count  <= 7'(count);
    end
  end

endmodule

[rtl/core/mhtq_ram.sv]
// Generic single-port RAM with registered read data.
module mhtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                    clk,
  input  logic [mhtq_pkg::addr_bits(DEPTH)-1:0]   addr,
  input  logic                                    we,
  input  logic [WIDTH-1:0]                        wdata,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/core/mhtq_cell.sv]
// One heap level: reads a sibling pair, decides, writes back and passes the token on.
module mhtq_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  mhtq_pkg::tok_t               tok_in,
  output mhtq_pkg::tok_t               tok_out,
  input  mhtq_pkg::wb_t                wb_in,
  output mhtq_pkg::wb_t                wb_out,
  output mhtq_pkg::stat_t              stat,
  output logic [mhtq_pkg::PAIR_W-1:0]  ram_addr,
  output logic                         ram_we,
  output mhtq_pkg::pair_t              ram_wdata,
  input  mhtq_pkg::pair_t              ram_rdata
);

  mhtq_pkg::tok_t  tok_q;
  mhtq_pkg::pair_t pair_q;
  logic [mhtq_pkg::NODE_W-1:0] k_in;

  mhtq_pkg::elem_t x;
  mhtq_pkg::elem_t pick;
  logic half;
  logic leaf;
  logic take;
  logic vl;
  logic vr;
  logic pick_r;
  logic go;
  logic [mhtq_pkg::NODE_W:0] left_idx;
  mhtq_pkg::pair_t ins_pair;
  mhtq_pkg::pair_t wb_pair;
  mhtq_pkg::tok_t  tok_next;
  mhtq_pkg::wb_t   wb_next;
  mhtq_pkg::stat_t stat_next;

  // Sift-down tokens carry the parent node; insert and fetch carry a path target.
  always_comb begin
    if (tok_in.op == mhtq_pkg::OP_SDN) begin
      k_in = tok_in.k;
    end else begin
      k_in = tok_in.t >> tok_in.s;
    end
  end

  always_comb begin
    half = tok_q.k[0];
    x    = half ? ram_rdata.odd : ram_rdata.even;
    leaf = (tok_q.s == '0);
    take = leaf || tok_q.disp || (tok_q.e.run_time < x.run_time);

    ins_pair = ram_rdata;
    if (half) begin
      ins_pair.odd = tok_q.e;
    end else begin
      ins_pair.even = tok_q.e;
    end

    left_idx = {tok_q.k, 1'b0};
    vl       = left_idx <= {1'b0, tok_q.n};
    vr       = (left_idx + (mhtq_pkg::NODE_W + 1)'(1)) <= {1'b0, tok_q.n};
    pick_r   = vr && (ram_rdata.odd.run_time < ram_rdata.even.run_time);
    pick     = pick_r ? ram_rdata.odd : ram_rdata.even;
    go       = vl && (pick.run_time < tok_q.e.run_time);

    wb_pair = pair_q;
    if (wb_in.k[0]) begin
      wb_pair.odd = wb_in.e;
    end else begin
      wb_pair.even = wb_in.e;
    end

    tok_next  = '0;
    wb_next   = '0;
    stat_next = '0;
    if (tok_q.valid) begin
      unique case (tok_q.op)
        mhtq_pkg::OP_INS: begin
          if (leaf) begin
            stat_next.done = 1'b1;
          end else begin
            tok_next      = tok_q;
            tok_next.s    = tok_q.s - mhtq_pkg::SHIFT_W'(1);
            tok_next.disp = tok_q.disp | take;
            tok_next.e    = take ? x : tok_q.e;
          end
        end
        mhtq_pkg::OP_FETCH: begin
          if (leaf) begin
            stat_next.fetch_valid = 1'b1;
            stat_next.fetch_elem  = x;
          end else begin
            tok_next   = tok_q;
            tok_next.s = tok_q.s - mhtq_pkg::SHIFT_W'(1);
          end
        end
        mhtq_pkg::OP_SDN: begin
          wb_next.valid = 1'b1;
          wb_next.last  = !go;
          wb_next.k     = tok_q.k;
          wb_next.e     = go ? pick : tok_q.e;
          if (go) begin
            tok_next   = tok_q;
            tok_next.k = left_idx[mhtq_pkg::NODE_W-1:0] | mhtq_pkg::NODE_W'(pick_r);
          end
        end
        default: begin
        end
      endcase
    end
    if (wb_in.valid && wb_in.last) begin
      stat_next.done = 1'b1;
    end

    // One port: write-backs from below, insert writes, then the read of a new token.
    if (wb_in.valid) begin
      ram_addr  = wb_in.k[mhtq_pkg::NODE_W-1:1];
      ram_we    = 1'b1;
      ram_wdata = wb_pair;
    end else if (tok_q.valid && (tok_q.op == mhtq_pkg::OP_INS) && take) begin
      ram_addr  = tok_q.k[mhtq_pkg::NODE_W-1:1];
      ram_we    = 1'b1;
      ram_wdata = ins_pair;
    end else begin
      if (tok_in.op == mhtq_pkg::OP_SDN) begin
        ram_addr = k_in[mhtq_pkg::PAIR_W-1:0];
      end else begin
        ram_addr = k_in[mhtq_pkg::NODE_W-1:1];
      end
      ram_we    = 1'b0;
      ram_wdata = ins_pair;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_q   <= '0;
      tok_out <= '0;
      wb_out  <= '0;
      stat    <= '0;
    end else begin
      tok_q   <= tok_in;
      tok_q.k <= k_in;
      tok_out <= tok_next;
      wb_out  <= wb_next;
      stat    <= stat_next;
    end
  end

  // The pair around the hole is kept for the write-back that the next level returns.
  always_ff @(posedge clk) begin
    if (tok_q.valid && (tok_q.op == mhtq_pkg::OP_SDN)) begin
      pair_q <= ram_rdata;
    end
  end

endmodule

[tb/mhtq_checker.sv]
// Checker of the min-heap timer queue: watches both channels, predicts each result and compares.
module mhtq_checker (
  input  logic clk,
  input  logic rst,
  mhtq_req_if  req,
  mhtq_rsp_if  rsp,
  output int   error_count,
  output int   pending
);
  import mhtq_pkg::*;

  typedef struct packed {
    logic [7:0]  earliest_id;
    logic [31:0] wait_time;
    logic        queue_empty;
    logic        overflow;
    logic [6:0]  task_count;
  } outcome_t;

  // Shadow heap of scheduled tasks, slot 0 is the earliest.
  logic [TIME_W-1:0] slot_time [CAPACITY];
  id_t               slot_id   [CAPACITY];
  int                held = 0;

  outcome_t due_results [$];
  int       mismatches = 0;
  int       backlog = 0;

  assign error_count = mismatches;
  assign pending     = backlog;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at %0t: %s is %0h, predicted %0h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic void swap_slots(int a, int b);
    logic [TIME_W-1:0] t;
    id_t               i;
    t = slot_time[a];
    i = slot_id[a];
    slot_time[a] = slot_time[b];
    slot_id[a]   = slot_id[b];
    slot_time[b] = t;
    slot_id[b]   = i;
  endfunction

  // A task climbs only past a parent that is due strictly later.
  function automatic void bubble_up(int pos);
    int parent;
    bit moving;
    moving = 1'b1;
    while (moving && pos > 0) begin
      parent = (pos - 1) / 2;
      moving = 1'b0;
      if (slot_time[pos] < slot_time[parent]) begin
        swap_slots(pos, parent);
        pos = parent;
        moving = 1'b1;
      end
    end
  endfunction

  // Of two children with the same time, the left one is taken.
  function automatic void bubble_down(int pos);
    int kid;
    bit moving;
    moving = 1'b1;
    while (moving) begin
      kid = 2 * pos + 1;
      moving = 1'b0;
      if (kid < held) begin
        if (kid + 1 < held && slot_time[kid + 1] < slot_time[kid]) kid++;
        if (slot_time[kid] < slot_time[pos]) begin
          swap_slots(kid, pos);
          pos = kid;
          moving = 1'b1;
        end
      end
    end
  endfunction

  function automatic outcome_t apply_request(logic [1:0] mode, id_t id,
                                             logic [31:0] tval, logic [31:0] now);
    outcome_t r;
    r = '0;
    case (mode)
      MODE_ADD: begin
        if (held >= CAPACITY) begin
          r.overflow = 1'b1;
        end else begin
          slot_time[held] = tval;
          slot_id[held]   = id;
          held++;
          bubble_up(held - 1);
        end
      end
      MODE_COMPLETE: begin
        if (held > 0) begin
          if (tval == '0) begin
            held--;
            slot_time[0] = slot_time[held];
            slot_id[0]   = slot_id[held];
          end else begin
            slot_time[0] = tval;
          end
          bubble_down(0);
        end
      end
      default: ;
    endcase
    if (held > 0) begin
      r.earliest_id = 8'(slot_id[0]);
      if (now < slot_time[0]) r.wait_time = slot_time[0] - now;
    end
    r.queue_empty = (held == 0);
    r.task_count  = 7'(held);
    return r;
  endfunction

  always @(posedge clk) begin
    outcome_t seen;
    outcome_t want;
    if (rst) begin
      held = 0;
      due_results.delete();
    end else begin
      if (req.valid && req.ready) begin
        due_results.push_back(apply_request(req.mode, ID_BITS'(req.task_id),
                                            req.time_value, req.now_time));
      end
      if (rsp.valid && rsp.ready) begin
        seen = '{rsp.earliest_id, rsp.wait_time, rsp.queue_empty, rsp.overflow,
                 rsp.task_count};
        if (due_results.size() == 0) begin
          report("result with none awaited, earliest_id", 32'(seen.earliest_id), 32'd0);
        end else begin
          want = due_results.pop_front();
          if (seen.earliest_id !== want.earliest_id)
            report("earliest_id", 32'(seen.earliest_id), 32'(want.earliest_id));
          if (seen.wait_time !== want.wait_time)
            report("wait_time", seen.wait_time, want.wait_time);
          if (seen.queue_empty !== want.queue_empty)
            report("queue_empty", 32'(seen.queue_empty), 32'(want.queue_empty));
          if (seen.overflow !== want.overflow)
            report("overflow", 32'(seen.overflow), 32'(want.overflow));
          if (seen.task_count !== want.task_count)
            report("task_count", 32'(seen.task_count), 32'(want.task_count));
        end
      end
    end
    backlog = due_results.size();
  end

endmodule

[tb/min_heap_timer_queue_test.sv]
// Top of the min-heap timer queue testbench: clock, reset, request traffic and the verdict.
module min_heap_timer_queue_test;
  import mhtq_pkg::*;

  // The block treats the unused mode code like a query.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Watchdog limit; the slowest correct run stays well under it, which leaves a wide margin.
  localparam int CYCLE_LIMIT = 400000;
  // Length of the long receiver hold-off that lets the block back up.
  localparam int HOLD_CYCLES = 300;
  // Extra wait after the last awaited result, so this covers any stragglers.
  localparam int DRAIN_CYCLES = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mhtq_req_if req ();
  mhtq_rsp_if rsp ();

  int error_count;
  int pending;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // The stimulus raises this to ask for one long hold-off; the receiver counts it out.
  logic hold_ask = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  int cycles = 0;

  min_heap_timer_queue dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  mhtq_checker watch (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .error_count (error_count),
    .pending     (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Every input of the block holds a known value from time zero.
  initial begin
    req.valid      = 1'b0;
    req.mode       = MODE_QUERY;
    req.task_id    = '0;
    req.time_value = '0;
    req.now_time   = '0;
    rsp.ready      = 1'b0;
  end

  // Receiver side. A rising hold_ask starts a long stretch with ready low; otherwise ready
  // drops at random in the share of cycles that recv_stall_pct gives.
  always begin
    @(negedge clk);
    if (hold_ask && !hold_seen) hold_left = HOLD_CYCLES;
    hold_seen = hold_ask;
    if (hold_left > 0) begin
      hold_left--;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // A run that hangs or loses a result ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("min_heap_timer_queue_test: done, errors");
      $finish;
    end
  end

  // Offers one request and returns at the falling edge after its transfer. It is entered at
  // a falling edge, so valid changes at most once per step; when the sender does not idle,
  // valid simply stays high into the next request.
  task automatic offer(input logic [1:0] mode, input logic [7:0] id,
                       input logic [31:0] tval, input logic [31:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid      <= 1'b1;
    req.mode       <= mode;
    req.task_id    <= id;
    req.time_value <= tval;
    req.now_time   <= now;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Times cluster in a small range so that equal run times and due tasks are common, with
  // a share near the top of the range and a share spread over all 32 bits.
  function automatic logic [31:0] pick_time();
    logic [31:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = $urandom_range(31);
      5, 6:          v = 32'hFFFF_FFE0 | $urandom_range(31);
      default:       v = $urandom;
    endcase
    return v;
  endfunction

  // One random request. add_w and retire_w are percentages; the rest is split between
  // reschedules, queries and the unused mode code.
  task automatic random_item(input int add_w, input int retire_w);
    int          roll;
    logic [31:0] tv;
    logic [7:0]  id;
    roll = $urandom_range(99);
    tv   = pick_time();
    id   = 8'($urandom_range(255));
    if (roll < add_w) begin
      offer(MODE_ADD, id, tv, pick_time());
    end else if (roll < add_w + retire_w) begin
      offer(MODE_COMPLETE, id, '0, pick_time());
    end else if (roll < add_w + retire_w + (100 - add_w - retire_w) / 2) begin
      offer(MODE_COMPLETE, id, (tv == '0) ? 32'd1 : tv, pick_time());
    end else if (roll < 96) begin
      offer(MODE_QUERY, id, tv, pick_time());
    end else begin
      offer(MODE_UNUSED, id, tv, pick_time());
    end
  endtask

  // A phase opens with a run that either fills the heap past capacity, so that adds get
  // dropped, or drains it to empty and beyond, and then goes on with mixed traffic.
  task automatic run_phase(input int idle_pct, input int stall_pct, input bit filling);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < 80; n++) begin
      if (filling) random_item(92, 2);
      else random_item(5, 80);
    end
    for (int n = 0; n < 30; n++) random_item(40, 25);
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed opening: empty queue, field extremes, ties and every mode.
    offer(MODE_QUERY,    8'h00, 32'h0000_0000, 32'hFFFF_FFFF);
    offer(MODE_COMPLETE, 8'h11, 32'd5,         32'd0);
    offer(MODE_COMPLETE, 8'h22, 32'd0,         32'd0);
    offer(MODE_UNUSED,   8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer(MODE_ADD,      8'hFF, 32'hFFFF_FFFF, 32'h0000_0000);
    offer(MODE_ADD,      8'h00, 32'h0000_0000, 32'hFFFF_FFFF);
    offer(MODE_ADD,      8'hA5, 32'd100,       32'd50);
    offer(MODE_ADD,      8'h5A, 32'd100,       32'd0);
    offer(MODE_ADD,      8'h3C, 32'd100,       32'd0);
    // Rescheduling the root to the same time as its children must leave it in place.
    offer(MODE_COMPLETE, 8'h00, 32'd100,       32'd99);
    offer(MODE_QUERY,    8'h00, 32'd0,         32'd100);
    offer(MODE_UNUSED,   8'h00, 32'd0,         32'd0);
    offer(MODE_COMPLETE, 8'h00, 32'd1,         32'd0);
    // Retire everything, then once more on the empty queue.
    repeat (6) offer(MODE_COMPLETE, 8'h00, 32'd0, 32'd0);
    offer(MODE_ADD,      8'h80, 32'd7,         32'd7);
    offer(MODE_ADD,      8'h01, 32'd6,         32'd0);
    offer(MODE_ADD,      8'h02, 32'd7,         32'd0);
    offer(MODE_COMPLETE, 8'h00, 32'hFFFF_FFFF, 32'd0);
    offer(MODE_QUERY,    8'h55, 32'hAAAA_AAAA, 32'h5555_5555);

    // Random traffic under each idling pattern.
    run_phase(0,  0,  1'b1);
    run_phase(84, 0,  1'b0);
    run_phase(0,  84, 1'b1);
    run_phase(14, 14, 1'b0);

    // Back-pressure: the receiver holds off for a long stretch while requests keep coming,
    // so the block fills its result stage and stops taking requests.
    hold_ask = 1'b1;
    run_phase(0, 0, 1'b1);
    hold_ask = 1'b0;

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    req.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (error_count == 0) begin
      $display("min_heap_timer_queue_test: done, clean");
    end else begin
      $display("min_heap_timer_queue_test: done, errors");
    end
    $finish;
  end

endmodule
